// File: sv/vrbrm_pkg.sv
// Shared types and constants for the voice queue resampling mixer.
`timescale 1ns / 1ps
package vrbrm_pkg;

	// Operation codes carried by the operation field.
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_MIX   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// Resampling step register.
	localparam int          STEP_W     = 19;
	localparam logic [18:0] STEP_RESET = 19'd65536;

	// Input and output field widths.
	localparam int MIX_W      = 20;
	localparam int TOTAL_W    = 17;
	localparam int OVR_W      = 32;
	localparam int SAMPLE_W   = 16;
	localparam int IDX_W      = 4;

	// Controller states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MIX    = 5'b00010,
		ST_DRAIN1 = 5'b00100,
		ST_DRAIN2 = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // any input transfer
		logic push;      // push transfer
		logic flush;     // flush transfer
		logic issue;     // visit one speaker during a mix
		logic load_out;  // capture the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a new result
	} status_t;

endpackage

// File: sv/voice_ring_buffer_resampling_mixer.sv
// Top level of the voice queue resampling mixer.
// Each speaker owns a circular sample queue in one shared memory of SPEAKERS x QUEUE_DEPTH
// entries. A push or flush goes from the idle state straight to the done state, where its
// result is registered into the output register. A mix goes through the mix state, where the
// controller visits one speaker per cycle, reading the head and next sample through the
// two memory read ports, then through the drain states while the read, multiply and
// accumulate stages drain, and on to the done state, where the result is registered.
// The next input is taken once the current result sits in the output register; the output
// register holds it until its transfer, and a result that waits there holds the next
// result in the done state, which delays the input after that.
`timescale 1ns / 1ps
module voice_ring_buffer_resampling_mixer
	import vrbrm_pkg::*;
#(
	parameter int SPEAKERS    = 16,
	parameter int QUEUE_DEPTH = 5760
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [STEP_W-1:0]          cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [IDX_W-1:0]           speaker_index,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [MIX_W-1:0]    mixed_sample,
	output logic                       overrun,
	output logic                       any_active,
	output logic [TOTAL_W-1:0]         total_queued,
	output logic [OVR_W-1:0]           overrun_total
);

	localparam int SW = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;

	cmd_t          cmd;
	status_t       status;
	logic [SW-1:0] mix_idx;

	// Operation sequencing.
	vrbrm_ctrl #(
		.SPEAKERS(SPEAKERS),
		.SW(SW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.status(status),
		.cmd(cmd),
		.mix_idx(mix_idx)
	);

	// Queue state, memory and arithmetic.
	vrbrm_dpath #(
		.SPEAKERS(SPEAKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.SW(SW)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.mix_idx(mix_idx),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.speaker_index(speaker_index),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mixed_sample(mixed_sample),
		.overrun(overrun),
		.any_active(any_active),
		.total_queued(total_queued),
		.overrun_total(overrun_total)
	);

endmodule

// File: sv/vrbrm_dpath.sv
// Datapath: queue state, sample memory, interpolation pipeline and output register.
`timescale 1ns / 1ps
module vrbrm_dpath
	import vrbrm_pkg::*;
#(
	parameter int SPEAKERS    = 16,
	parameter int QUEUE_DEPTH = 5760,
	parameter int SW          = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic [SW-1:0]              mix_idx,
	output status_t                    status,
	input  logic                       cfg_we,
	input  logic [STEP_W-1:0]          cfg_wdata,
	input  logic [IDX_W-1:0]           speaker_index,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [MIX_W-1:0]    mixed_sample,
	output logic                       overrun,
	output logic                       any_active,
	output logic [TOTAL_W-1:0]         total_queued,
	output logic [OVR_W-1:0]           overrun_total
);

	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int FW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = SPEAKERS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = $clog2(DEPTH + 1);
	localparam int TW    = (QW > TOTAL_W) ? QW : TOTAL_W;
	localparam int ACW   = 17 + SW;
	localparam int EW    = ACW + 4;

	logic [STEP_W-1:0] step_q;
	logic [PW-1:0]     head_q  [SPEAKERS];
	logic [FW-1:0]     fill_q  [SPEAKERS];
	logic [15:0]       phase_q [SPEAKERS];
	logic [QW-1:0]     qsum_q;
	logic [OVR_W-1:0]  ovr_q;
	logic              dropped_q;
	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];

	logic [SW-1:0] sel;
	logic [PW-1:0] cur_head;
	logic [FW-1:0] cur_fill;
	logic [15:0]   cur_phase;
	logic          spk_ok, full;
	logic [PW:0]   head_inc, tail_sum, adv_sum;
	logic [PW-1:0] head_next, tail_pos, head_adv, b_pos;
	logic [19:0]   ph;
	logic [FW-1:0] adv, fill_new;
	logic [AW-1:0] base, wr_addr, rd_a_addr, rd_b_addr;
	logic          mix_active;

	// Per-speaker state of the speaker being pushed, flushed or mixed.
	always_comb begin
		sel       = cmd.issue ? mix_idx : SW'(speaker_index);
		cur_head  = head_q[sel];
		cur_fill  = fill_q[sel];
		cur_phase = phase_q[sel];
		spk_ok    = (7'(speaker_index) < 7'(SPEAKERS));
		full      = (cur_fill >= FW'(QUEUE_DEPTH));
		head_inc  = (PW+1)'(cur_head) + (PW+1)'(1);
		head_next = (head_inc >= (PW+1)'(QUEUE_DEPTH)) ? '0 : PW'(head_inc);
		tail_sum  = (PW+1)'(cur_head) + (PW+1)'(cur_fill);
		tail_pos  = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
			PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
		// A full queue drops its head and the new sample takes that slot.
		if (full) begin
			tail_pos = cur_head;
		end
		ph       = 20'(cur_phase) + 20'(step_q);
		adv      = (FW'(ph[19:16]) < cur_fill) ? FW'(ph[19:16]) : cur_fill;
		adv_sum  = (PW+1)'(cur_head) + (PW+1)'(adv);
		head_adv = (adv_sum >= (PW+1)'(QUEUE_DEPTH)) ?
			PW'(adv_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(adv_sum);
		fill_new = cur_fill - adv;
		b_pos    = (cur_fill > FW'(1)) ? head_next : cur_head;
		base      = AW'(sel) * AW'(QUEUE_DEPTH);
		wr_addr   = base + AW'(tail_pos);
		rd_a_addr = base + AW'(cur_head);
		rd_b_addr = base + AW'(b_pos);
		mix_active = cmd.issue && (cur_fill != '0);
	end

	// Step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// Queue bookkeeping for push, flush and each mix visit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SPEAKERS; i++) begin
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
				phase_q[i] <= '0;
			end
			qsum_q    <= '0;
			ovr_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				dropped_q <= cmd.push && spk_ok && full;
			end
			if (cmd.push && spk_ok) begin
				if (full) begin
					head_q[sel]  <= head_next;
					phase_q[sel] <= '0;
					ovr_q        <= ovr_q + OVR_W'(1);
				end else begin
					fill_q[sel] <= cur_fill + FW'(1);
					qsum_q      <= qsum_q + QW'(1);
				end
			end else if (cmd.flush && spk_ok) begin
				head_q[sel]  <= '0;
				fill_q[sel]  <= '0;
				phase_q[sel] <= '0;
				qsum_q       <= qsum_q - QW'(cur_fill);
			end else if (mix_active) begin
				head_q[sel]  <= head_adv;
				fill_q[sel]  <= fill_new;
				phase_q[sel] <= (fill_new != '0) ? ph[15:0] : 16'd0;
				qsum_q       <= qsum_q - QW'(adv);
			end
		end
	end

	// Sample memory: one write port, two registered read ports.
	logic signed [SAMPLE_W-1:0] rd_a_s1, rd_b_s1;
	always_ff @(posedge clk) begin
		if (cmd.push && spk_ok) begin
			mem_q[wr_addr] <= sample_value;
		end
		rd_a_s1 <= mem_q[rd_a_addr];
		rd_b_s1 <= mem_q[rd_b_addr];
	end

	// Interpolation pipeline: read, multiply, accumulate.
	logic              v_s1, v_s2;
	logic [15:0]       phase_s1;
	logic signed [33:0] prod_s2;
	logic signed [SAMPLE_W-1:0] a_s2;
	logic signed [ACW-1:0] acc_q;
	logic signed [16:0] diff;
	logic signed [16:0] phase_sx;
	logic signed [17:0] frac_term;

	always_comb begin
		diff      = 17'(rd_b_s1) - 17'(rd_a_s1);
		phase_sx  = signed'({1'b0, phase_s1});
		frac_term = prod_s2[33:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mix_active;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= cur_phase;
		prod_s2  <= 34'(phase_sx) * 34'(diff);
		a_s2     <= rd_a_s1;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACW'(a_s2) + ACW'(frac_term);
		end
	end

	// Saturation of the mix sum and the queued total.
	logic signed [EW-1:0] acc_ext;
	logic signed [MIX_W-1:0] mix_sat;
	logic [TW-1:0] qsum_ext;
	always_comb begin
		acc_ext = EW'(acc_q);
		if (acc_ext > EW'(524287)) begin
			mix_sat = 20'sd524287;
		end else if (acc_ext < -EW'(524288)) begin
			mix_sat = -20'sd524288;
		end else begin
			mix_sat = MIX_W'(acc_ext);
		end
		qsum_ext = TW'(qsum_q);
	end

	// Output register; it frees up when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mixed_sample  <= mix_sat;
			overrun       <= dropped_q;
			any_active    <= (qsum_q != '0);
			total_queued  <= (qsum_ext > TW'(131071)) ? 17'd131071 : TOTAL_W'(qsum_ext);
			overrun_total <= ovr_q;
		end
	end

	assign status.out_free = !out_valid || out_ready;

endmodule

// File: sv/vrbrm_ctrl.sv
// Controller: sequences each operation and the speaker sweep of a mix.
`timescale 1ns / 1ps
module vrbrm_ctrl
	import vrbrm_pkg::*;
#(
	parameter int SPEAKERS = 16,
	parameter int SW       = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    operation,
	input  status_t       status,
	output cmd_t          cmd,
	output logic [SW-1:0] mix_idx
);

	state_t        state_q;
	logic [SW-1:0] idx_q;
	logic          xfer;

	// Command decode.
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		xfer         = in_valid && in_ready;
		cmd.start    = xfer;
		cmd.push     = xfer && (operation == OP_PUSH);
		cmd.flush    = xfer && (operation == OP_FLUSH);
		cmd.issue    = (state_q == ST_MIX);
		cmd.load_out = (state_q == ST_DONE) && status.out_free;
		mix_idx      = idx_q;
	end

	// State sequence and speaker counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (xfer) begin
						state_q <= (operation == OP_MIX) ? ST_MIX : ST_DONE;
					end
				end
				ST_MIX: begin
					if (idx_q == SW'(SPEAKERS - 1)) begin
						state_q <= ST_DRAIN1;
					end
					idx_q <= idx_q + SW'(1);
				end
				ST_DRAIN1: begin
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/voice_ring_buffer_resampling_mixer_tb.sv
// Self-checking testbench for the voice queue resampling mixer.
`timescale 1ns / 1ps
module voice_ring_buffer_resampling_mixer_tb;
	import vrbrm_pkg::*;

	localparam int SPK   = 16;
	localparam int DEPTH = 5760;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]                 op;
		logic [IDX_W-1:0]           spk;
		logic signed [SAMPLE_W-1:0] smp;
	} voice_cmd_t;

	typedef struct packed {
		logic signed [MIX_W-1:0] mix;
		logic                    ovr;
		logic                    active;
		logic [TOTAL_W-1:0]      queued;
		logic [OVR_W-1:0]        ovr_total;
	} mix_status_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [STEP_W-1:0]          cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 operation;
	logic [IDX_W-1:0]           speaker_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [MIX_W-1:0]    mixed_sample;
	logic                       overrun;
	logic                       any_active;
	logic [TOTAL_W-1:0]         total_queued;
	logic [OVR_W-1:0]           overrun_total;

	// Predictor state.
	logic signed [15:0] pcm_mem [SPK][DEPTH];
	int unsigned        q_head [SPK];
	int unsigned        q_fill [SPK];
	int unsigned        q_phase [SPK];
	logic [31:0]        drop_count;
	int unsigned        queued_count;
	int unsigned        step_reg;

	voice_cmd_t  pending_cmds [$];
	mix_status_t expected_status [$];
	int          error_count;
	int          idle_cycles;
	int          sink_idle;
	bit          in_taken;
	bit          allow_idle;
	bit          hold_sink;
	bit          pause_source;
	int          sink_hold_len;

	voice_ring_buffer_resampling_mixer #(.SPEAKERS(SPK), .QUEUE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.speaker_index(speaker_index), .sample_value(sample_value),
		.out_valid(out_valid), .out_ready(out_ready), .mixed_sample(mixed_sample),
		.overrun(overrun), .any_active(any_active), .total_queued(total_queued),
		.overrun_total(overrun_total)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Floor division by 65536 of a signed product.
	function automatic longint floor_q16(longint p);
		if (p >= 0) return p >>> 16;
		return -(((-p) + 65535) >>> 16);
	endfunction

	// Apply one command to the predictor and return its status.
	function automatic mix_status_t predict_status(voice_cmd_t c);
		mix_status_t r;
		longint      sum;
		longint      a;
		longint      b;
		int unsigned ph;
		int unsigned adv;
		int unsigned s;
		r = '0;
		sum = 0;
		s = c.spk;
		if (c.op == OP_PUSH) begin
			if (q_fill[s] >= DEPTH) begin
				q_head[s] = (q_head[s] + 1) % DEPTH;
				q_fill[s]--;
				queued_count--;
				q_phase[s] = 0;
				drop_count++;
				r.ovr = 1'b1;
			end
			pcm_mem[s][(q_head[s] + q_fill[s]) % DEPTH] = c.smp;
			q_fill[s]++;
			queued_count++;
		end else if (c.op == OP_MIX) begin
			for (int i = 0; i < SPK; i++) begin
				if (q_fill[i] != 0) begin
					a = pcm_mem[i][q_head[i]];
					b = pcm_mem[i][(q_head[i] + (q_fill[i] > 1 ? 1 : 0)) % DEPTH];
					sum += a + floor_q16(longint'(q_phase[i]) * (b - a));
					ph = q_phase[i] + step_reg;
					adv = ph >> 16;
					if (adv > q_fill[i]) adv = q_fill[i];
					q_head[i] = (q_head[i] + adv) % DEPTH;
					q_fill[i] -= adv;
					queued_count -= adv;
					q_phase[i] = (q_fill[i] != 0) ? (ph & 32'hFFFF) : 0;
				end
			end
			if (sum > 524287) sum = 524287;
			if (sum < -524288) sum = -524288;
		end else if (c.op == OP_FLUSH) begin
			queued_count -= q_fill[s];
			q_fill[s] = 0;
			q_head[s] = 0;
			q_phase[s] = 0;
		end
		r.mix = sum[MIX_W-1:0];
		r.active = (queued_count != 0);
		r.queued = (queued_count > 131071) ? 17'd131071 : queued_count[TOTAL_W-1:0];
		r.ovr_total = drop_count;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d", field, got, want);
		error_count++;
	endtask

	// Input transfers: predict the result of each accepted command.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_status.push_back(predict_status(pending_cmds.pop_front()));
			in_taken = 1'b1;
		end
	end

	// Source side: offer queued commands, with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (idle_cycles > 0) begin
					idle_cycles--;
					in_valid <= 1'b0;
				end else if (allow_idle && $urandom_range(0, 9) == 0) begin
					idle_cycles = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (!pause_source && pending_cmds.size() > 0) begin
					voice_cmd_t nx;
					nx = pending_cmds[0];
					in_valid <= 1'b1;
					operation <= nx.op;
					speaker_index <= nx.spk;
					sample_value <= nx.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: random stalls plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_sink) begin
				out_ready <= 1'b0;
				if (sink_hold_len > 0) sink_hold_len--;
			end else if (sink_idle > 0) begin
				sink_idle--;
				out_ready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				sink_idle = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				mix_status_t e;
				e = expected_status.pop_front();
				if (mixed_sample !== e.mix) report_mismatch("mixed_sample", mixed_sample, e.mix);
				if (overrun !== e.ovr) report_mismatch("overrun", overrun, e.ovr);
				if (any_active !== e.active) report_mismatch("any_active", any_active, e.active);
				if (total_queued !== e.queued)
					report_mismatch("total_queued", total_queued, e.queued);
				if (overrun_total !== e.ovr_total)
					report_mismatch("overrun_total", overrun_total, e.ovr_total);
			end
		end
	end

	// Watchdog on cycles with no transfer at all, outside the sink hold-off.
	int stall_cycles;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || hold_sink)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic voice_cmd_t make_cmd(logic [1:0] op, int spk, int smp);
		voice_cmd_t c;
		c.op = op;
		c.spk = spk[IDX_W-1:0];
		c.smp = smp[15:0];
		return c;
	endfunction

	function automatic voice_cmd_t random_cmd(int push_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_weight)
			return make_cmd(OP_PUSH, $urandom_range(0, 15), $urandom);
		if (r < 97)
			return make_cmd(OP_MIX, $urandom_range(0, 15), $urandom);
		if (r < 99)
			return make_cmd(OP_FLUSH, $urandom_range(0, 15), $urandom);
		return make_cmd(2'd3, $urandom_range(0, 15), $urandom);
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_status.size() != 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_step(int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[STEP_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		step_reg = v & 32'h7FFFF;
	endtask

	task automatic add_random(int n, int push_weight);
		for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd(push_weight));
	endtask

	initial begin
		int unsigned steps [6];
		error_count = 0;
		idle_cycles = 0;
		sink_idle = 0;
		in_taken = 1'b0;
		allow_idle = 1'b1;
		hold_sink = 1'b0;
		pause_source = 1'b0;
		sink_hold_len = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		operation = OP_PUSH;
		speaker_index = '0;
		sample_value = '0;
		foreach (q_head[i]) begin
			q_head[i] = 0;
			q_fill[i] = 0;
			q_phase[i] = 0;
		end
		drop_count = '0;
		queued_count = 0;
		step_reg = STEP_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every operation, single-sample queue, flush, odd code.
		pending_cmds.push_back(make_cmd(OP_MIX, 0, 0));
		pending_cmds.push_back(make_cmd(OP_PUSH, 0, 32767));
		pending_cmds.push_back(make_cmd(OP_MIX, 0, 0));
		pending_cmds.push_back(make_cmd(OP_PUSH, 15, -32768));
		pending_cmds.push_back(make_cmd(OP_PUSH, 15, 32767));
		pending_cmds.push_back(make_cmd(OP_PUSH, 15, -1));
		for (int i = 0; i < 16; i++) pending_cmds.push_back(make_cmd(OP_PUSH, i, -32768));
		pending_cmds.push_back(make_cmd(OP_MIX, 5, 12345));
		pending_cmds.push_back(make_cmd(2'd3, 9, 21845));
		pending_cmds.push_back(make_cmd(OP_FLUSH, 15, -21846));
		pending_cmds.push_back(make_cmd(OP_FLUSH, 3, 0));
		wait_drained();

		// Sweep the step register, extremes included, with random traffic.
		steps = '{16384, 393216, 0, 524287, 98304, 40000};
		foreach (steps[k]) begin
			write_step(steps[k]);
			add_random(150, 55);
			wait_drained();
		end

		// Load one queue with a burst of pushes, then drain it with mixes.
		write_step(65536);
		for (int i = 0; i < 20; i++)
			pending_cmds.push_back(make_cmd(OP_PUSH, 7, $urandom));
		for (int i = 0; i < 30; i++) pending_cmds.push_back(make_cmd(OP_MIX, 0, 0));
		wait_drained();
		write_step(393216);
		add_random(200, 40);

		// Long receiver hold-off while the sender keeps offering.
		hold_sink = 1'b1;
		sink_hold_len = 300;
		while (sink_hold_len > 0) @(posedge clk);
		hold_sink = 1'b0;

		// Sender pause until every expected result has arrived.
		pause_source = 1'b1;
		while (expected_status.size() != 0 || in_valid) @(posedge clk);
		pause_source = 1'b0;
		wait_drained();
		write_step(70000);
		add_random(300, 60);
		wait_drained();

		// Final stretch with no idling.
		allow_idle = 1'b0;
		add_random(200, 50);
		wait_drained();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
